// ===== design/dfmpa_pkg.sv =====
// Shared types and constants for the depth frame minimum proximity alarm.
package dfmpa_pkg;

  // Frame geometry limits
  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned MAX_ROWS = 1024;
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);

  // Field widths
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned WGT_W    = 4;
  localparam int unsigned FILT_W   = 20;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned PROD_W   = 48;

  // Divide-by-ten reciprocal: floor(x / 10) = (x * RECIP10) >> RECIP_SH for x < 2**24
  localparam logic [SUM_W-1:0] RECIP10  = 24'hCCCCCD;
  localparam int unsigned      RECIP_SH = 27;

  localparam logic [WGT_W-1:0] WGT_FULL = 4'd10;

  // Frame summary queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VALID_DEPTH = 2'd0,
    CFG_NEW_WEIGHT      = 2'd1,
    CFG_ALARM_THRESHOLD = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_index_e;

  // Frame summary passed from scanner to filter
  typedef struct packed {
    logic               found;
    logic [DEPTH_W-1:0] min_depth;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               guard;
  } frame_sum_t;

endpackage

// ===== design/dfmpa_scan.sv =====
// Pixel scanner: tracks raster position and the first frame minimum.
module dfmpa_scan
  import dfmpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               px_take_i,
  input  logic [DEPTH_W-1:0] depth_mm_i,
  input  logic               row_end_i,
  input  logic               frame_end_i,
  input  logic               guard_mode_i,
  input  logic [DEPTH_W-1:0] min_valid_depth_i,
  output logic               push_o,
  output frame_sum_t         sum_o
);

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [DEPTH_W-1:0] run_min_q, run_min_d;
  logic               any_q, any_d;
  logic [POS_W-1:0]   best_row_q, best_row_d;
  logic [POS_W-1:0]   best_col_q, best_col_d;

  logic               px_valid;
  logic               px_better;
  logic               cur_found;
  logic [DEPTH_W-1:0] cur_min;
  logic [POS_W-1:0]   cur_row;
  logic [POS_W-1:0]   cur_col;

  // Minimum candidate including the pixel on the port
  assign px_valid  = depth_mm_i > min_valid_depth_i;
  assign px_better = px_valid && (!any_q || depth_mm_i < run_min_q);
  assign cur_found = any_q || px_valid;
  assign cur_min   = px_better ? depth_mm_i : run_min_q;
  assign cur_row   = px_better ? POS_W'(row_q) : best_row_q;
  assign cur_col   = px_better ? POS_W'(col_q) : best_col_q;

  // Summary pushed on the frame's last pixel; empty frame reports zeros
  assign push_o          = px_take_i && frame_end_i;
  assign sum_o.found     = cur_found;
  assign sum_o.min_depth = cur_found ? cur_min : '0;
  assign sum_o.row       = cur_found ? cur_row : '0;
  assign sum_o.col       = cur_found ? cur_col : '0;
  assign sum_o.guard     = guard_mode_i;

  // Next-state for position and running minimum
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    run_min_d  = run_min_q;
    any_d      = any_q;
    best_row_d = best_row_q;
    best_col_d = best_col_q;
    if (px_take_i) begin
      if (frame_end_i) begin
        col_d      = '0;
        row_d      = '0;
        run_min_d  = '1;
        any_d      = 1'b0;
        best_row_d = '0;
        best_col_d = '0;
      end else begin
        run_min_d  = cur_min;
        any_d      = cur_found;
        best_row_d = cur_row;
        best_col_d = cur_col;
        if (row_end_i) begin
          col_d = '0;
          if (row_q < ROW_W'(MAX_ROWS - 1)) begin
            row_d = row_q + 1'b1;
          end
        end else if (col_q < COL_W'(MAX_COLS - 1)) begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      run_min_q  <= '1;
      any_q      <= 1'b0;
      best_row_q <= '0;
      best_col_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      run_min_q  <= run_min_d;
      any_q      <= any_d;
      best_row_q <= best_row_d;
      best_col_q <= best_col_d;
    end
  end

endmodule

// ===== design/dfmpa_fifo.sv =====
// Short queue of frame summaries between scanner and filter.
module dfmpa_fifo
  import dfmpa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_sum_t push_data_i,
  input  logic       pop_i,
  output frame_sum_t pop_data_o,
  output logic       full_o,
  output logic       empty_o
);

  frame_sum_t           mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o     = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? FIFO_AW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? FIFO_AW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/dfmpa_filter.sv =====
// Range filter: weighted average of frame minimum, alarm compare and result register.
module dfmpa_filter
  import dfmpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  frame_sum_t         sum_i,
  output logic               pop_o,
  input  logic [WGT_W-1:0]   new_weight_i,
  input  logic [DEPTH_W-1:0] alarm_threshold_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [DEPTH_W-1:0] min_depth_mm_o,
  output logic [POS_W-1:0]   min_row_o,
  output logic [POS_W-1:0]   min_col_o,
  output logic [FILT_W-1:0]  filtered_range_o,
  output logic               loiter_request_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } flt_state_e;

  flt_state_e         state_q, state_d;
  frame_sum_t         item_q;
  logic [SUM_W-1:0]   sum_q;
  logic [FILT_W-1:0]  prod_q;
  logic [FILT_W-1:0]  filt_q, filt_d;
  logic               started_q, started_d;

  logic               out_valid_q, out_valid_d;
  logic               found_q;
  logic [DEPTH_W-1:0] min_depth_q;
  logic [POS_W-1:0]   min_row_q;
  logic [POS_W-1:0]   min_col_q;
  logic [FILT_W-1:0]  range_q;
  logic               loiter_q;

  logic [WGT_W-1:0]   w_sat;
  logic [WGT_W-1:0]   w_old;
  logic [FILT_W-1:0]  cur;
  logic [FILT_W-1:0]  old;
  logic [SUM_W-1:0]   sum_d;
  logic [FILT_W-1:0]  quot;
  logic [FILT_W-1:0]  thr16;
  logic               out_free;
  logic               load_out;

  // Weighted sum w*cur + (10-w)*old + 5, weights above ten act as ten
  assign w_sat = (new_weight_i > WGT_FULL) ? WGT_FULL : new_weight_i;
  assign w_old = WGT_FULL - w_sat;
  assign cur   = {item_q.min_depth, 4'b0000};
  assign old   = started_q ? filt_q : cur;
  assign sum_d = SUM_W'(w_sat) * SUM_W'(cur) + SUM_W'(w_old) * SUM_W'(old) + SUM_W'(5);

  // Quotient by ten via reciprocal, kept to the filter width
  assign quot  = prod_q;
  assign thr16 = {alarm_threshold_i, 4'b0000};

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_DONE) && out_free;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  // Sequencer for one frame summary
  always_comb begin
    state_d     = state_q;
    filt_d      = filt_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          filt_d      = quot;
          started_d   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      filt_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filt_q      <= filt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= sum_i;
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_d;
    end
    if (state_q == ST_DIV) begin
      prod_q <= FILT_W'((PROD_W'(sum_q) * PROD_W'(RECIP10)) >> RECIP_SH);
    end
    if (load_out) begin
      found_q     <= item_q.found;
      min_depth_q <= item_q.min_depth;
      min_row_q   <= item_q.row;
      min_col_q   <= item_q.col;
      range_q     <= quot;
      loiter_q    <= item_q.guard && (quot < thr16);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign min_depth_mm_o   = min_depth_q;
  assign min_row_o        = min_row_q;
  assign min_col_o        = min_col_q;
  assign filtered_range_o = range_q;
  assign loiter_request_o = loiter_q;

endmodule

// ===== design/depth_frame_min_proximity_alarm_unit.sv =====
// Top level of the depth frame minimum proximity alarm.
// Depth pixels enter in raster order, one per clock, and are never held back
// except when four frame summaries are already queued for the filter. Each
// frame's last pixel yields one result. The filter sequencer takes one summary
// at a time through dequeue, weighted sum, divide-by-ten multiply and result
// load in turn, so back-to-back frames with fewer pixels than those steps fill
// the queue. Results wait in an output register while the scanner keeps
// taking pixels. Configuration writes are always ready and take effect at once.
module depth_frame_min_proximity_alarm_unit
  import dfmpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DEPTH_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DEPTH_W-1:0]   in_depth_mm_i,
  input  logic                 in_row_end_i,
  input  logic                 in_frame_end_i,
  input  logic                 in_guard_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 out_found_o,
  output logic [DEPTH_W-1:0]   out_min_depth_mm_o,
  output logic [POS_W-1:0]     out_min_row_o,
  output logic [POS_W-1:0]     out_min_col_o,
  output logic [FILT_W-1:0]    out_filtered_range_o,
  output logic                 out_loiter_request_o
);

  logic [DEPTH_W-1:0] min_valid_q;
  logic [WGT_W-1:0]   weight_q;
  logic [DEPTH_W-1:0] threshold_q;

  logic       px_take;
  logic       push;
  frame_sum_t push_data;
  logic       pop;
  frame_sum_t pop_data;
  logic       fifo_full;
  logic       fifo_empty;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_valid_q <= DEPTH_W'(10);
      weight_q    <= WGT_W'(3);
      threshold_q <= DEPTH_W'(550);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_VALID_DEPTH: min_valid_q <= cfg_data_i;
        CFG_NEW_WEIGHT:      weight_q    <= cfg_data_i[WGT_W-1:0];
        CFG_ALARM_THRESHOLD: threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = fifo_full;
  assign px_take    = in_valid_i && !in_stall_o;

  dfmpa_scan u_scan (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .px_take_i         (px_take),
    .depth_mm_i        (in_depth_mm_i),
    .row_end_i         (in_row_end_i),
    .frame_end_i       (in_frame_end_i),
    .guard_mode_i      (in_guard_mode_i),
    .min_valid_depth_i (min_valid_q),
    .push_o            (push),
    .sum_o             (push_data)
  );

  dfmpa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  dfmpa_filter u_filter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (fifo_empty),
    .sum_i             (pop_data),
    .pop_o             (pop),
    .new_weight_i      (weight_q),
    .alarm_threshold_i (threshold_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .found_o           (out_found_o),
    .min_depth_mm_o    (out_min_depth_mm_o),
    .min_row_o         (out_min_row_o),
    .min_col_o         (out_min_col_o),
    .filtered_range_o  (out_filtered_range_o),
    .loiter_request_o  (out_loiter_request_o)
  );

endmodule

// ===== design/dfmpa_checker.sv =====
// Port-level checks for the depth frame minimum proximity alarm.
module dfmpa_checker
  import dfmpa_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               out_found_o,
  input logic [DEPTH_W-1:0] out_min_depth_mm_o,
  input logic [POS_W-1:0]   out_min_row_o,
  input logic [POS_W-1:0]   out_min_col_o,
  input logic [FILT_W-1:0]  out_filtered_range_o
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its minimum depth, filtered range and row
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_min_depth_mm_o) &&
      $stable(out_filtered_range_o) && $stable(out_min_row_o))
    else $error("stalled result changed");

  // Empty frame reports zero minimum and position
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_found_o |->
      out_min_depth_mm_o == '0 && out_min_row_o == '0 && out_min_col_o == '0)
    else $error("empty frame reported nonzero minimum");

  // A found minimum lies strictly above the validity floor, so never zero
  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_found_o |-> out_min_depth_mm_o != '0)
    else $error("found minimum is zero");

endmodule

bind depth_frame_min_proximity_alarm_unit dfmpa_checker u_dfmpa_checker (.*);

// ===== tb/depth_frame_min_proximity_alarm_checker.sv =====
// Frame-minimum alarm predictor and result checker, watching the block's channels.
`timescale 1ns / 1ps

module depth_frame_min_proximity_alarm_checker
  import dfmpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DEPTH_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [DEPTH_W-1:0]   in_depth_mm_i,
  input  logic                 in_row_end_i,
  input  logic                 in_frame_end_i,
  input  logic                 in_guard_mode_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 out_found_i,
  input  logic [DEPTH_W-1:0]   out_min_depth_mm_i,
  input  logic [POS_W-1:0]     out_min_row_i,
  input  logic [POS_W-1:0]     out_min_col_i,
  input  logic [FILT_W-1:0]    out_filtered_range_i,
  input  logic                 out_loiter_request_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o
);

  // One frame summary as the block reports it
  typedef struct packed {
    logic               found;
    logic [DEPTH_W-1:0] min_depth;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [FILT_W-1:0]  filt;
    logic               loiter;
  } frame_alarm_t;

  frame_alarm_t alarm_q[$];

  // Register copies
  int unsigned floor_mm;
  int unsigned new_weight;
  int unsigned threshold_mm;

  // Scanner and filter state
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned frame_min;
  bit          have_min;
  int unsigned best_row;
  int unsigned best_col;
  int unsigned range_q4;
  bit          range_seeded;

  int unsigned err_count;
  int unsigned done_count;

  function automatic void clear_frame();
    col_pos   = 0;
    row_pos   = 0;
    frame_min = 16'hFFFF;
    have_min  = 1'b0;
    best_row  = 0;
    best_col  = 0;
  endfunction

  // Advance the frame scan by one pixel; on the frame's last pixel queue its summary
  function automatic void scan_pixel(logic [DEPTH_W-1:0] depth, logic row_end,
                                     logic frame_end, logic guard);
    frame_alarm_t rec;
    int unsigned  cur;
    int unsigned  prev;
    int unsigned  w;
    int unsigned  total;
    if (depth > floor_mm && (!have_min || depth < frame_min)) begin
      frame_min = 32'(depth);
      have_min  = 1'b1;
      best_row  = row_pos;
      best_col  = col_pos;
    end
    if (!frame_end) begin
      if (row_end) begin
        col_pos = 0;
        if (row_pos < MAX_ROWS - 1) row_pos++;
      end else if (col_pos < MAX_COLS - 1) begin
        col_pos++;
      end
      return;
    end
    rec.found     = have_min;
    rec.min_depth = have_min ? frame_min[DEPTH_W-1:0] : '0;
    rec.row       = have_min ? best_row[POS_W-1:0] : '0;
    rec.col       = have_min ? best_col[POS_W-1:0] : '0;
    // Exponential filter in 1/16 mm, seeded by the first frame
    cur   = int'(rec.min_depth) * 16;
    w     = (new_weight > WGT_FULL) ? int'(WGT_FULL) : new_weight;
    prev  = range_seeded ? range_q4 : cur;
    total = w * cur + (int'(WGT_FULL) - w) * prev + 5;
    range_q4     = (total / 10) & 32'hF_FFFF;
    range_seeded = 1'b1;
    rec.filt   = range_q4[FILT_W-1:0];
    rec.loiter = guard && (range_q4 < threshold_mm * 16);
    alarm_q.push_back(rec);
    clear_frame();
  endfunction

  function automatic int unsigned field_diff(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_alarm_t want;
    int unsigned  bad;
    if (!rst_ni) begin
      floor_mm     = 10;
      new_weight   = 3;
      threshold_mm = 550;
      clear_frame();
      range_q4     = 0;
      range_seeded = 1'b0;
      alarm_q.delete();
      err_count    = 0;
      done_count   = 0;
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // Register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_MIN_VALID_DEPTH: floor_mm     = 32'(cfg_data_i);
          CFG_NEW_WEIGHT:      new_weight   = 32'(cfg_data_i[WGT_W-1:0]);
          CFG_ALARM_THRESHOLD: threshold_mm = 32'(cfg_data_i);
          default: ;
        endcase
      end
      // Pixel transaction
      if (in_valid_i && !in_stall_i)
        scan_pixel(in_depth_mm_i, in_row_end_i, in_frame_end_i, in_guard_mode_i);
      // Result transaction
      if (out_valid_i && !out_stall_i) begin
        if (alarm_q.size() == 0) begin
          $error("frame result arrived with no frame pending");
          err_count++;
        end else begin
          want = alarm_q.pop_front();
          bad  = 0;
          bad += field_diff("found", 32'(want.found), 32'(out_found_i));
          bad += field_diff("min_depth_mm", 32'(want.min_depth), 32'(out_min_depth_mm_i));
          bad += field_diff("min_row", 32'(want.row), 32'(out_min_row_i));
          bad += field_diff("min_col", 32'(want.col), 32'(out_min_col_i));
          bad += field_diff("filtered_range", 32'(want.filt), 32'(out_filtered_range_i));
          bad += field_diff("loiter_request", 32'(want.loiter), 32'(out_loiter_request_i));
          if (bad != 0) err_count++;
          done_count++;
        end
      end
      errors_o  <= err_count;
      pending_o <= alarm_q.size();
      checked_o <= done_count;
    end
  end

endmodule

// ===== tb/depth_frame_min_proximity_alarm_unit_test.sv =====
// Stimulus and verdict for the depth frame minimum proximity alarm unit.
`timescale 1ns / 1ps

module depth_frame_min_proximity_alarm_unit_test;
  import dfmpa_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_PIXELS  = 60;
  localparam int unsigned LONG_LINE     = 1030;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [DEPTH_W-1:0]   cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [DEPTH_W-1:0]   in_depth     = '0;
  logic                 in_row_end   = 1'b0;
  logic                 in_frame_end = 1'b0;
  logic                 in_guard     = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 out_found;
  logic [DEPTH_W-1:0]   out_min_depth;
  logic [POS_W-1:0]     out_min_row;
  logic [POS_W-1:0]     out_min_col;
  logic [FILT_W-1:0]    out_filt;
  logic                 out_loiter;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_seq      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned pixels_sent   = 0;
  int unsigned cur_floor     = 10;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  depth_frame_min_proximity_alarm_unit u_dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .in_depth_mm_i        (in_depth),
    .in_row_end_i         (in_row_end),
    .in_frame_end_i       (in_frame_end),
    .in_guard_mode_i      (in_guard),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .out_found_o          (out_found),
    .out_min_depth_mm_o   (out_min_depth),
    .out_min_row_o        (out_min_row),
    .out_min_col_o        (out_min_col),
    .out_filtered_range_o (out_filt),
    .out_loiter_request_o (out_loiter)
  );

  depth_frame_min_proximity_alarm_checker u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_i          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .in_depth_mm_i        (in_depth),
    .in_row_end_i         (in_row_end),
    .in_frame_end_i       (in_frame_end),
    .in_guard_mode_i      (in_guard),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .out_found_i          (out_found),
    .out_min_depth_mm_i   (out_min_depth),
    .out_min_row_i        (out_min_row),
    .out_min_col_i        (out_min_col),
    .out_filtered_range_i (out_filt),
    .out_loiter_request_i (out_loiter),
    .errors_o             (errors),
    .pending_o            (pending),
    .checked_o            (checked)
  );

  // Result side: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Depth mix: ignored pixels, values just over the floor (ties), all-ones, anything
  function automatic logic [DEPTH_W-1:0] pick_depth();
    int unsigned v;
    case ($urandom_range(7))
      0:       v = $urandom_range(cur_floor, 0);
      1, 2:    v = cur_floor + 1 + $urandom_range(2);
      3:       v = 16'hFFFF;
      default: v = $urandom_range(16'hFFFF, 0);
    endcase
    if (v > 16'hFFFF) v = 16'hFFFF;
    return v[DEPTH_W-1:0];
  endfunction

  // Leaves valid high with the accepted payload; the next call or a drain replaces it
  task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic row_end,
                            input logic frame_end, input logic guard);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_depth     <= depth;
    in_row_end   <= row_end;
    in_frame_end <= frame_end;
    in_guard     <= guard;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned rows, input int unsigned cols, input bit ragged);
    logic last;
    logic re;
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        last = (r == rows - 1) && (c == cols - 1);
        re   = ragged ? ($urandom_range(3) == 0) : (c == cols - 1);
        if (last) re = 1'($urandom_range(1));
        send_pixel(pick_depth(), re, last, 1'($urandom_range(1)));
      end
    end
  endtask

  // One long row or one long column; the minimum lies past the saturation point
  task automatic send_long_frame(input bit vertical);
    logic [DEPTH_W-1:0] d;
    logic               last;
    for (int unsigned i = 0; i < LONG_LINE; i++) begin
      last = (i == LONG_LINE - 1);
      d    = (i + 4 < LONG_LINE) ? DEPTH_W'($urandom_range(16'hFFFF, 50000)) :
                                   DEPTH_W'(1000);
      send_pixel(d, vertical && !last, last, 1'($urandom_range(1)));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it
  task automatic write_reg(input cfg_index_e idx, input logic [DEPTH_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [DEPTH_W-1:0] floor_v,
                               input logic [WGT_W-1:0] wgt,
                               input logic [DEPTH_W-1:0] thr);
    write_reg(CFG_MIN_VALID_DEPTH, floor_v);
    write_reg(CFG_NEW_WEIGHT, DEPTH_W'(wgt));
    write_reg(CFG_ALARM_THRESHOLD, thr);
    cfg_valid <= 1'b0;
    cur_floor = 32'(floor_v);
  endtask

  task automatic random_setting();
    logic [DEPTH_W-1:0] fl;
    logic [DEPTH_W-1:0] thr;
    case ($urandom_range(5))
      0:       fl = '0;
      1:       fl = 16'hFFFF;
      2, 3:    fl = DEPTH_W'($urandom_range(300));
      default: fl = DEPTH_W'($urandom_range(16'hFFFF));
    endcase
    case ($urandom_range(4))
      0:       thr = '0;
      1:       thr = 16'hFFFF;
      default: thr = DEPTH_W'($urandom_range(16'hFFFF));
    endcase
    apply_setting(fl, WGT_W'($urandom_range(15)), thr);
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned frames;
    int unsigned sel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 29; recv_idle_pct <= 62; end
        1: begin send_idle_pct = 62; recv_idle_pct <= 29; end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase

      if (ph == 0) begin
        // Empty frame seeds the filter with zero
        send_pixel(16'd0, 1'b0, 1'b1, 1'b1);
        // Pixel at the floor ignored, tie keeps the first, larger and smaller-than-floor later
        send_pixel(16'd10, 1'b0, 1'b0, 1'b0);
        send_pixel(16'd11, 1'b0, 1'b0, 1'b0);
        send_pixel(16'd11, 1'b1, 1'b0, 1'b0);
        send_pixel(16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_pixel(16'd11, 1'b0, 1'b0, 1'b0);
        send_pixel(16'd5, 1'b0, 1'b1, 1'b1);
        // All-ones pixel is a valid minimum; both marks on one pixel
        send_pixel(16'hFFFF, 1'b1, 1'b1, 1'b0);
        // Minimum on the second row
        send_pixel(16'd200, 1'b1, 1'b0, 1'b0);
        send_pixel(16'd100, 1'b0, 1'b0, 1'b0);
        send_pixel(16'd100, 1'b0, 1'b1, 1'b1);
        drain_results();
        // Weight above ten, floor at zero, top threshold
        apply_setting(16'd0, 4'd15, 16'hFFFF);
        send_pixel(16'd1, 1'b0, 1'b0, 1'b1);
        send_pixel(16'd0, 1'b0, 1'b1, 1'b1);
        drain_results();
        // Zero weight, nothing can pass the floor, zero threshold
        apply_setting(16'hFFFF, 4'd0, 16'd0);
        send_pixel(16'hFFFF, 1'b0, 1'b0, 1'b1);
        send_pixel(16'd0, 1'b0, 1'b1, 1'b1);
        drain_results();
        // Full weight and reset-like values; the spare index must change nothing
        write_reg(CFG_UNUSED, DEPTH_W'($urandom_range(16'hFFFF)));
        apply_setting(16'd10, WGT_FULL, 16'd550);
        send_pixel(16'd300, 1'b0, 1'b1, 1'b1);
        drain_results();
      end

      if (ph == 2) begin
        // Long result hold while single-pixel frames keep coming
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 40; i++)
          send_pixel(pick_depth(), 1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)));
        drain_results();
        // Column or row counter runs into saturation
        apply_setting(16'd10, 4'd3, 16'd550);
        send_long_frame(1'($urandom_range(1)));
        drain_results();
      end

      // Random frames, mostly small and well formed, with a fresh setting now and then
      phase_start = pixels_sent;
      frames      = 0;
      while (pixels_sent - phase_start < PHASE_PIXELS) begin
        sel = $urandom_range(19);
        if (sel < 3)
          send_frame(1, 1, 1'b0);
        else if (sel < 6)
          send_frame($urandom_range(5, 1), $urandom_range(8, 1), 1'b1);
        else
          send_frame($urandom_range(4, 1), $urandom_range(6, 1), 1'b0);
        frames++;
        if (frames % 3 == 0) begin
          drain_results();
          random_setting();
        end
      end
      drain_results();
    end

    $display("run: %0d pixels sent, %0d frame results checked under three stall patterns",
             pixels_sent, checked);
    $display("run: floor, weight and threshold swept to their extremes, incl. position saturation");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== depth_frame_min_proximity_alarm_unit.f =====
design/dfmpa_pkg.sv
design/dfmpa_scan.sv
design/dfmpa_fifo.sv
design/dfmpa_filter.sv
design/depth_frame_min_proximity_alarm_unit.sv
design/dfmpa_checker.sv
tb/depth_frame_min_proximity_alarm_checker.sv
tb/depth_frame_min_proximity_alarm_unit_test.sv
